FILE: sv/seg_pkg.sv
// shared constants for the segment intersection pipeline
// no dependencies
package seg_pkg;
	localparam int COORD_WIDTH_DEF = 16;
	localparam int TOL_WIDTH       = 15;
	localparam int CROSS_WIDTH     = 32;
	// quotient bits kept by the divider, the top one flags overflow
	localparam int QUOT_BITS       = 34;
	localparam int CMP_WIDTH       = CROSS_WIDTH + 3;
endpackage

FILE: sv/seg_in_if.sv
// input channel: two segments as eight signed coordinates
// no dependencies
interface seg_in_if #(parameter int W = 16);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] seg1_start_x;
	logic signed [W-1:0] seg1_start_y;
	logic signed [W-1:0] seg1_end_x;
	logic signed [W-1:0] seg1_end_y;
	logic signed [W-1:0] seg2_start_x;
	logic signed [W-1:0] seg2_start_y;
	logic signed [W-1:0] seg2_end_x;
	logic signed [W-1:0] seg2_end_y;
	modport source (output valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
		seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y, input ready);
	modport sink (input valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
		seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y, output ready);
endinterface

FILE: sv/seg_out_if.sv
// result channel: hit and parallel flags plus the intersection point
// uses seg_pkg
interface seg_out_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   hit;
	logic                                   parallel;
	logic signed [seg_pkg::CROSS_WIDTH-1:0] cross_x;
	logic signed [seg_pkg::CROSS_WIDTH-1:0] cross_y;
	modport source (output valid, hit, parallel, cross_x, cross_y, input ready);
	modport sink (input valid, hit, parallel, cross_x, cross_y, output ready);
endinterface

FILE: sv/segment_intersection_2d.sv
// pipeline: 5 multiply/subtract stages, 35 divider stages (one operand register then one
// quotient bit per stage for 34 bits), one output register
// throughput: one item per cycle; the whole pipeline holds while the result is not taken
// reset: arst_n clears all valid bits and sets tolerance to zero
// uses seg_pkg, seg_in_if, seg_out_if, seg_arith, seg_div
module segment_intersection_2d #(
	parameter int COORD_WIDTH = seg_pkg::COORD_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	seg_in_if.sink                           segs,
	seg_out_if.source                        result,
	input  logic                             cfg_we,
	input  logic [seg_pkg::TOL_WIDTH-1:0]    cfg_wdata
);
	localparam int W  = COORD_WIDTH;
	localparam int NW = 3*W + 3;
	localparam int DW = 2*W + 3;
	localparam int SW = 4*W + 1;
	localparam int QB = seg_pkg::QUOT_BITS;
	localparam int CW = seg_pkg::CROSS_WIDTH;
	localparam int HW = seg_pkg::CMP_WIDTH;

	logic en;
	logic [seg_pkg::TOL_WIDTH-1:0] tol_q;
	logic a_valid;
	logic signed [DW-1:0] a_den;
	logic signed [NW-1:0] a_nx, a_ny;
	logic signed [W-1:0]  a_lox, a_hix, a_loy, a_hiy;
	logic [SW-1:0] side_in, side_out;
	logic d_valid;
	logic [QB-1:0] qx, qy;
	logic neg_x, neg_y;
	logic signed [CW-1:0] cx, cy;
	logic signed [HW-1:0] cx_w, cy_w, tol_w, lox_w, hix_w, loy_w, hiy_w;
	logic par, hit_c;
	logic out_v_q, hit_q, par_q;
	logic signed [CW-1:0] cx_q, cy_q;

	assign en         = !out_v_q || result.ready;
	assign segs.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	seg_arith #(.W(W)) u_arith (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(segs.valid),
		.x1(segs.seg1_start_x), .y1(segs.seg1_start_y),
		.x2(segs.seg1_end_x),   .y2(segs.seg1_end_y),
		.x3(segs.seg2_start_x), .y3(segs.seg2_start_y),
		.x4(segs.seg2_end_x),   .y4(segs.seg2_end_y),
		.out_valid(a_valid), .den(a_den), .nx(a_nx), .ny(a_ny),
		.lo_x(a_lox), .hi_x(a_hix), .lo_y(a_loy), .hi_y(a_hiy)
	);

	assign side_in = {a_den == '0, a_lox, a_hix, a_loy, a_hiy};

	seg_div #(.NW(NW), .DW(DW), .SW(SW)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(a_valid),
		.nx(a_nx), .ny(a_ny), .den(a_den), .side_in(side_in),
		.out_valid(d_valid), .qx(qx), .qy(qy), .neg_x(neg_x), .neg_y(neg_y),
		.side_out(side_out)
	);

	// top quotient bit means the magnitude reached 2^33
	always_comb begin
		if (neg_x) begin
			cx = (qx[QB-1] || qx[QB-2:0] > (QB-1)'(33'h080000000)) ?
				{1'b1, {(CW-1){1'b0}}} : CW'(-qx[QB-2:0]);
		end else begin
			cx = (qx[QB-1] || qx[QB-2:0] > (QB-1)'(33'h07fffffff)) ?
				{1'b0, {(CW-1){1'b1}}} : CW'(qx[QB-2:0]);
		end
		if (neg_y) begin
			cy = (qy[QB-1] || qy[QB-2:0] > (QB-1)'(33'h080000000)) ?
				{1'b1, {(CW-1){1'b0}}} : CW'(-qy[QB-2:0]);
		end else begin
			cy = (qy[QB-1] || qy[QB-2:0] > (QB-1)'(33'h07fffffff)) ?
				{1'b0, {(CW-1){1'b1}}} : CW'(qy[QB-2:0]);
		end
	end

	assign par   = side_out[SW-1];
	assign lox_w = HW'(signed'(side_out[4*W-1:3*W]));
	assign hix_w = HW'(signed'(side_out[3*W-1:2*W]));
	assign loy_w = HW'(signed'(side_out[2*W-1:W]));
	assign hiy_w = HW'(signed'(side_out[W-1:0]));
	assign cx_w  = HW'(cx);
	assign cy_w  = HW'(cy);
	assign tol_w = signed'(HW'(tol_q));
	assign hit_c = (cx_w + tol_w >= lox_w) && (cx_w - tol_w <= hix_w) &&
		(cy_w + tol_w >= loy_w) && (cy_w - tol_w <= hiy_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			par_q <= par;
			hit_q <= !par && hit_c;
			cx_q  <= par ? '0 : cx;
			cy_q  <= par ? '0 : cy;
		end
	end

	assign result.valid    = out_v_q;
	assign result.hit      = hit_q;
	assign result.parallel = par_q;
	assign result.cross_x  = cx_q;
	assign result.cross_y  = cy_q;

	a_par_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && par_q |-> cx_q == '0 && cy_q == '0 && !hit_q)
		else $error("parallel result with nonzero point or hit");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		segs.ready == (!out_v_q || result.ready))
		else $error("input ready not tied to output stage");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !result.ready |=> out_v_q && $stable(cx_q) && $stable(hit_q))
		else $error("stalled result changed");
endmodule

FILE: sv/seg_arith.sv
// five-stage multiply/subtract pipeline forming denominator, numerators and overlap bounds
// no package dependencies
module seg_arith #(
	parameter int W = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic signed [W-1:0]     x1,
	input  logic signed [W-1:0]     y1,
	input  logic signed [W-1:0]     x2,
	input  logic signed [W-1:0]     y2,
	input  logic signed [W-1:0]     x3,
	input  logic signed [W-1:0]     y3,
	input  logic signed [W-1:0]     x4,
	input  logic signed [W-1:0]     y4,
	output logic                    out_valid,
	output logic signed [2*W+2:0]   den,
	output logic signed [3*W+2:0]   nx,
	output logic signed [3*W+2:0]   ny,
	output logic signed [W-1:0]     lo_x,
	output logic signed [W-1:0]     hi_x,
	output logic signed [W-1:0]     lo_y,
	output logic signed [W-1:0]     hi_y
);
	logic [4:0] v_q;
	logic signed [W-1:0] mnx12, mnx34, mxx12, mxx34, mny12, mny34, mxy12, mxy34;
	logic signed [W-1:0] x1_s1, y1_s1, x2_s1, y2_s1, x3_s1, y3_s1, x4_s1, y4_s1;
	logic signed [W:0]   dx12_s1, dy12_s1, dx34_s1, dy34_s1;
	logic signed [W:0]   dx12_s2, dy12_s2, dx34_s2, dy34_s2;
	logic signed [W:0]   dx12_s3, dy12_s3, dx34_s3, dy34_s3;
	logic signed [2*W+1:0] pa_s2, pb_s2;
	logic signed [2*W-1:0] m1_s2, m2_s2, m3_s2, m4_s2;
	logic signed [2*W+2:0] den_s3, den_s4, den_s5;
	logic signed [2*W:0]   f1_s3, f2_s3;
	logic signed [3*W+1:0] a1_s4, a2_s4, a3_s4, a4_s4;
	logic signed [3*W+2:0] nx_s5, ny_s5;
	logic signed [W-1:0] lox_s1, hix_s1, loy_s1, hiy_s1;
	logic signed [W-1:0] lox_s2, hix_s2, loy_s2, hiy_s2;
	logic signed [W-1:0] lox_s3, hix_s3, loy_s3, hiy_s3;
	logic signed [W-1:0] lox_s4, hix_s4, loy_s4, hiy_s4;
	logic signed [W-1:0] lox_s5, hix_s5, loy_s5, hiy_s5;

	assign mnx12 = (x1 < x2) ? x1 : x2;
	assign mxx12 = (x1 < x2) ? x2 : x1;
	assign mnx34 = (x3 < x4) ? x3 : x4;
	assign mxx34 = (x3 < x4) ? x4 : x3;
	assign mny12 = (y1 < y2) ? y1 : y2;
	assign mxy12 = (y1 < y2) ? y2 : y1;
	assign mny34 = (y3 < y4) ? y3 : y4;
	assign mxy34 = (y3 < y4) ? y4 : y3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[3:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1 <= x1; y1_s1 <= y1; x2_s1 <= x2; y2_s1 <= y2;
			x3_s1 <= x3; y3_s1 <= y3; x4_s1 <= x4; y4_s1 <= y4;
			dx12_s1 <= (W+1)'(x1) - (W+1)'(x2);
			dy12_s1 <= (W+1)'(y1) - (W+1)'(y2);
			dx34_s1 <= (W+1)'(x3) - (W+1)'(x4);
			dy34_s1 <= (W+1)'(y3) - (W+1)'(y4);
			lox_s1 <= (mnx12 > mnx34) ? mnx12 : mnx34;
			hix_s1 <= (mxx12 < mxx34) ? mxx12 : mxx34;
			loy_s1 <= (mny12 > mny34) ? mny12 : mny34;
			hiy_s1 <= (mxy12 < mxy34) ? mxy12 : mxy34;

			pa_s2 <= dx12_s1 * dy34_s1;
			pb_s2 <= dy12_s1 * dx34_s1;
			m1_s2 <= x1_s1 * y2_s1;
			m2_s2 <= y1_s1 * x2_s1;
			m3_s2 <= x3_s1 * y4_s1;
			m4_s2 <= y3_s1 * x4_s1;
			dx12_s2 <= dx12_s1; dy12_s2 <= dy12_s1;
			dx34_s2 <= dx34_s1; dy34_s2 <= dy34_s1;
			lox_s2 <= lox_s1; hix_s2 <= hix_s1; loy_s2 <= loy_s1; hiy_s2 <= hiy_s1;

			den_s3 <= (2*W+3)'(pa_s2) - (2*W+3)'(pb_s2);
			f1_s3 <= (2*W+1)'(m1_s2) - (2*W+1)'(m2_s2);
			f2_s3 <= (2*W+1)'(m3_s2) - (2*W+1)'(m4_s2);
			dx12_s3 <= dx12_s2; dy12_s3 <= dy12_s2;
			dx34_s3 <= dx34_s2; dy34_s3 <= dy34_s2;
			lox_s3 <= lox_s2; hix_s3 <= hix_s2; loy_s3 <= loy_s2; hiy_s3 <= hiy_s2;

			a1_s4 <= f1_s3 * dx34_s3;
			a2_s4 <= dx12_s3 * f2_s3;
			a3_s4 <= f1_s3 * dy34_s3;
			a4_s4 <= dy12_s3 * f2_s3;
			den_s4 <= den_s3;
			lox_s4 <= lox_s3; hix_s4 <= hix_s3; loy_s4 <= loy_s3; hiy_s4 <= hiy_s3;

			nx_s5 <= (3*W+3)'(a1_s4) - (3*W+3)'(a2_s4);
			ny_s5 <= (3*W+3)'(a3_s4) - (3*W+3)'(a4_s4);
			den_s5 <= den_s4;
			lox_s5 <= lox_s4; hix_s5 <= hix_s4; loy_s5 <= loy_s4; hiy_s5 <= hiy_s4;
		end
	end

	assign out_valid = v_q[4];
	assign den  = den_s5;
	assign nx   = nx_s5;
	assign ny   = ny_s5;
	assign lo_x = lox_s5;
	assign hi_x = hix_s5;
	assign lo_y = loy_s5;
	assign hi_y = hiy_s5;
endmodule

FILE: sv/seg_div.sv
// restoring divider pipeline, one quotient bit per stage, x and y in lockstep
// uses seg_pkg
module seg_div #(
	parameter int NW = 51,
	parameter int DW = 35,
	parameter int SW = 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic signed [NW-1:0]                nx,
	input  logic signed [NW-1:0]                ny,
	input  logic signed [DW-1:0]                den,
	input  logic [SW-1:0]                       side_in,
	output logic                                out_valid,
	output logic [seg_pkg::QUOT_BITS-1:0]       qx,
	output logic [seg_pkg::QUOT_BITS-1:0]       qy,
	output logic                                neg_x,
	output logic                                neg_y,
	output logic [SW-1:0]                       side_out
);
	localparam int QB  = seg_pkg::QUOT_BITS;
	localparam int KW0 = (NW > DW + QB) ? NW : DW + QB;
	localparam int KW  = KW0 + 1;

	logic [QB:0]    v_s;
	logic [KW-1:0]  rx_s [0:QB];
	logic [KW-1:0]  ry_s [0:QB];
	logic [DW-1:0]  d_s  [0:QB];
	logic [QB-1:0]  qx_s [0:QB];
	logic [QB-1:0]  qy_s [0:QB];
	logic [QB:0]    nx_neg_s;
	logic [QB:0]    ny_neg_s;
	logic [SW-1:0]  sd_s [0:QB];
	logic [NW-1:0]  absnx, absny;
	logic [DW-1:0]  absd;

	assign absnx = nx[NW-1] ? NW'(-nx) : NW'(nx);
	assign absny = ny[NW-1] ? NW'(-ny) : NW'(ny);
	assign absd  = den[DW-1] ? DW'(-den) : DW'(den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s[0] <= KW'(absnx);
			ry_s[0] <= KW'(absny);
			d_s[0]  <= absd;
			qx_s[0] <= '0;
			qy_s[0] <= '0;
			nx_neg_s[0] <= nx[NW-1] ^ den[DW-1];
			ny_neg_s[0] <= ny[NW-1] ^ den[DW-1];
			sd_s[0] <= side_in;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_bit
		localparam int B = QB - 1 - k;
		logic [KW-1:0] dsh;
		logic          gx, gy;
		assign dsh = KW'(d_s[k]) << B;
		assign gx  = rx_s[k] >= dsh;
		assign gy  = ry_s[k] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[k+1] <= gx ? rx_s[k] - dsh : rx_s[k];
				ry_s[k+1] <= gy ? ry_s[k] - dsh : ry_s[k];
				qx_s[k+1] <= qx_s[k] | (QB'(gx) << B);
				qy_s[k+1] <= qy_s[k] | (QB'(gy) << B);
				d_s[k+1]  <= d_s[k];
				nx_neg_s[k+1] <= nx_neg_s[k];
				ny_neg_s[k+1] <= ny_neg_s[k];
				sd_s[k+1] <= sd_s[k];
			end
		end
	end

	assign out_valid = v_s[QB];
	assign qx        = qx_s[QB];
	assign qy        = qy_s[QB];
	assign neg_x     = nx_neg_s[QB];
	assign neg_y     = ny_neg_s[QB];
	assign side_out  = sd_s[QB];
endmodule

FILE: sim/segment_intersection_2d_test.sv
// self-checking testbench for segment_intersection_2d: random and directed segment pairs,
// results checked against a behavioral intersection calculation
// depends on seg_pkg, seg_in_if, seg_out_if and the rtl of segment_intersection_2d
`timescale 1ns / 1ps

module segment_intersection_2d_test;
	localparam int W = seg_pkg::COORD_WIDTH_DEF;
	localparam int TOL_WIDTH = seg_pkg::TOL_WIDTH;
	localparam int CROSS_WIDTH = seg_pkg::CROSS_WIDTH;
	localparam int LATENCY = 41;
	localparam int STALL_LIMIT = 5000;

	typedef logic signed [W-1:0] coord_t;
	typedef struct packed {
		coord_t x1, y1, x2, y2, x3, y3, x4, y4;
	} seg_pair_t;
	typedef struct packed {
		logic hit;
		logic parallel;
		logic signed [CROSS_WIDTH-1:0] cx;
		logic signed [CROSS_WIDTH-1:0] cy;
	} crossing_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [TOL_WIDTH-1:0] cfg_wdata;
	logic [TOL_WIDTH-1:0] tol_model;

	seg_in_if #(.W(W)) segs ();
	seg_out_if result ();

	segment_intersection_2d #(.COORD_WIDTH(W)) dut (
		.clk(clk), .arst_n(arst_n), .segs(segs), .result(result),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	crossing_t pending_crossings[$];
	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	logic rx_stall_mode = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// truncating toward zero, then clamp to 32 bits
	function automatic logic signed [CROSS_WIDTH-1:0] quotient_sat(
		logic signed [127:0] n, logic signed [127:0] d);
		logic signed [127:0] q;
		q = n / d;
		if (q > 128'sd2147483647) return 32'sh7fffffff;
		if (q < -128'sd2147483648) return 32'sh80000000;
		return q[CROSS_WIDTH-1:0];
	endfunction

	function automatic logic signed [63:0] min2(logic signed [63:0] a, logic signed [63:0] b);
		return a < b ? a : b;
	endfunction

	function automatic logic signed [63:0] max2(logic signed [63:0] a, logic signed [63:0] b);
		return a > b ? a : b;
	endfunction

	function automatic crossing_t predict_crossing(seg_pair_t s, logic [TOL_WIDTH-1:0] tol);
		logic signed [127:0] x1, y1, x2, y2, x3, y3, x4, y4, den, f1, f2, nx, ny;
		logic signed [63:0] cx, cy, t;
		crossing_t r;
		x1 = s.x1; y1 = s.y1; x2 = s.x2; y2 = s.y2;
		x3 = s.x3; y3 = s.y3; x4 = s.x4; y4 = s.y4;
		t = {49'd0, tol};
		r = '0;
		den = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
		if (den == 0) begin
			r.parallel = 1'b1;
			return r;
		end
		f1 = x1 * y2 - y1 * x2;
		f2 = x3 * y4 - y3 * x4;
		nx = f1 * (x3 - x4) - (x1 - x2) * f2;
		ny = f1 * (y3 - y4) - (y1 - y2) * f2;
		r.cx = quotient_sat(nx, den);
		r.cy = quotient_sat(ny, den);
		cx = r.cx;
		cy = r.cy;
		r.hit = (cx + t >= max2(min2(s.x1, s.x2), min2(s.x3, s.x4)))
			&& (cx - t <= min2(max2(s.x1, s.x2), max2(s.x3, s.x4)))
			&& (cy + t >= max2(min2(s.y1, s.y2), min2(s.y3, s.y4)))
			&& (cy - t <= min2(max2(s.y1, s.y2), max2(s.y3, s.y4)));
		return r;
	endfunction

	// watchdog and result checking
	always @(posedge clk) begin
		crossing_t want;
		if (segs.valid && segs.ready || result.valid && result.ready)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("segment_intersection_2d verification failed");
			$finish;
		end
		if (arst_n && result.valid && result.ready) begin
			if (pending_crossings.size() == 0) begin
				$display("%0t unexpected result item hit=%b par=%b x=%0d y=%0d", $time,
					result.hit, result.parallel, result.cross_x, result.cross_y);
				errors++;
			end else begin
				want = pending_crossings.pop_front();
				if (result.hit !== want.hit) begin
					$display("%0t hit expected %b actual %b", $time, want.hit, result.hit);
					errors++;
				end
				if (result.parallel !== want.parallel) begin
					$display("%0t parallel expected %b actual %b", $time, want.parallel,
						result.parallel);
					errors++;
				end
				if (result.cross_x !== want.cx) begin
					$display("%0t cross_x expected %0d actual %0d", $time, want.cx,
						result.cross_x);
					errors++;
				end
				if (result.cross_y !== want.cy) begin
					$display("%0t cross_y expected %0d actual %0d", $time, want.cy,
						result.cross_y);
					errors++;
				end
			end
		end
	end

	// receiver stall pattern: switches between always ready and random stalls
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			rx_stall_mode <= ~rx_stall_mode;
		if (rx_stall_mode)
			result.ready <= ($urandom_range(0, 3) != 0);
		else
			result.ready <= 1'b1;
	end

	task automatic send_pair(seg_pair_t s);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				segs.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		segs.valid <= 1'b1;
		{segs.seg1_start_x, segs.seg1_start_y, segs.seg1_end_x, segs.seg1_end_y,
			segs.seg2_start_x, segs.seg2_start_y, segs.seg2_end_x, segs.seg2_end_y} <= s;
		@(posedge clk);
		while (!segs.ready) @(posedge clk);
		pending_crossings.push_back(predict_crossing(s, tol_model));
		burst_left--;
	endtask

	task automatic drain;
		segs.valid <= 1'b0;
		burst_left = 0;
		while (pending_crossings.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic set_tolerance(logic [TOL_WIDTH-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tol_model = v;
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 3))
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 512)) - coord_t'(256);
			2: return $urandom_range(0, 1) ? coord_t'(16'sh7fff) : coord_t'(16'sh8000);
			default: return coord_t'($urandom_range(0, 4096)) - coord_t'(2048);
		endcase
	endfunction

	function automatic seg_pair_t rand_pair();
		seg_pair_t s;
		s = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord(), rand_coord(), rand_coord()};
		case ($urandom_range(0, 7))
			// second segment parallel to the first, shifted
			0: begin
				s.x3 = s.x1 + coord_t'($urandom_range(0, 64));
				s.y3 = s.y1;
				s.x4 = s.x2 + coord_t'($urandom_range(0, 64)) - s.x1 + s.x3 - s.x3;
				s.x4 = s.x3 + (s.x2 - s.x1);
				s.y4 = s.y3 + (s.y2 - s.y1);
			end
			// degenerate first segment
			1: begin
				s.x2 = s.x1;
				s.y2 = s.y1;
			end
			// crossing segments sharing a midpoint region
			2, 3: begin
				s.x1 = coord_t'($urandom_range(0, 1024)) - coord_t'(512);
				s.y1 = coord_t'($urandom_range(0, 1024)) - coord_t'(512);
				s.x2 = -s.x1;
				s.y2 = -s.y1;
				s.x3 = coord_t'($urandom_range(0, 1024)) - coord_t'(512);
				s.y3 = coord_t'($urandom_range(0, 1024)) - coord_t'(512);
				s.x4 = -s.x3 + coord_t'($urandom_range(0, 8)) - coord_t'(4);
				s.y4 = -s.y3 + coord_t'($urandom_range(0, 8)) - coord_t'(4);
			end
			// second segment from the first's end points, start nudged in x and end in y
			4: begin
				s.x3 = s.x1 + coord_t'(1);
				s.y3 = s.y1;
				s.x4 = s.x2;
				s.y4 = s.y2 + coord_t'($urandom_range(1, 2));
			end
			default: ;
		endcase
		return s;
	endfunction

	task automatic test_directed;
		seg_pair_t s;
		coord_t mx, mn;
		mx = 16'sh7fff;
		mn = 16'sh8000;
		// plain crossing at the origin
		send_pair({-16'sd256, -16'sd256, 16'sd256, 16'sd256,
			-16'sd256, 16'sd256, 16'sd256, -16'sd256});
		// miss: lines cross outside the segments
		send_pair({16'sd0, 16'sd0, 16'sd256, 16'sd0,
			16'sd1024, -16'sd256, 16'sd1024, 16'sd256});
		// parallel lines and a degenerate segment
		send_pair({16'sd0, 16'sd0, 16'sd256, 16'sd256,
			16'sd0, 16'sd256, 16'sd256, 16'sd512});
		send_pair({16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd0, 16'sd0, 16'sd7, 16'sd9});
		send_pair('0);
		// coordinate extremes
		send_pair({mn, mn, mx, mx, mn, mx, mx, mn});
		send_pair({mx, mx, mn, mn, mx, mn, mn, mx});
		send_pair({mn, mn, mx, mn, mn, mx, mx, mx});
		send_pair({mn, mn, mn, mx, mx, mn, mx, mx});
		// nearly parallel pairs that meet at a shared end point
		send_pair({mn, mn, mx, mx, mn, mn + coord_t'(1), mx, mx});
		send_pair({mx, mn, mn, mx, mx, mn + coord_t'(1), mn, mx});
		send_pair({16'sd0, 16'sd0, mx, 16'sd1, 16'sd0, 16'sd1, mx, 16'sd1});
		// negative quotient truncation toward zero
		send_pair({16'sd0, 16'sd0, 16'sd3, 16'sd1, 16'sd0, -16'sd1, 16'sd7, -16'sd1});
		send_pair({-16'sd3, 16'sd2, 16'sd5, -16'sd7, 16'sd1, 16'sd1, -16'sd2, 16'sd9});
		// tangent just past an end point
		send_pair({16'sd0, 16'sd0, 16'sd256, 16'sd0,
			16'sd260, -16'sd256, 16'sd260, 16'sd256});
		s = {16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555,
			16'sh1234, 16'shedcb, 16'shfedc, 16'sh0123};
		send_pair(s);
		send_pair(~s);
		drain();
	endtask

	task automatic test_tolerance;
		// near miss that only counts as a hit with slack
		seg_pair_t s;
		s = {16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd260, -16'sd256, 16'sd260, 16'sd256};
		set_tolerance(15'd4);
		send_pair(s);
		drain();
		set_tolerance(15'd3);
		send_pair(s);
		drain();
		set_tolerance(15'h7fff);
		send_pair(s);
		send_pair({16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
			16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
		drain();
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			if (i % 400 == 399) begin
				drain();
				case ($urandom_range(0, 3))
					0: set_tolerance('0);
					1: set_tolerance('1);
					default: set_tolerance(TOL_WIDTH'($urandom_range(0, 300)));
				endcase
			end
			send_pair(rand_pair());
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		tol_model = '0;
		segs.valid = 1'b0;
		{segs.seg1_start_x, segs.seg1_start_y, segs.seg1_end_x, segs.seg1_end_y,
			segs.seg2_start_x, segs.seg2_start_y, segs.seg2_end_x, segs.seg2_end_y} = '0;
		result.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_tolerance();
		set_tolerance('0);
		test_random(1620);
		if (errors == 0)
			$display("segment_intersection_2d verification clean");
		else
			$display("segment_intersection_2d verification failed");
		$finish;
	end
endmodule

FILE: sim.f
sv/seg_pkg.sv
sv/seg_in_if.sv
sv/seg_out_if.sv
sv/seg_arith.sv
sv/seg_div.sv
sv/segment_intersection_2d.sv
sim/segment_intersection_2d_test.sv
